### rtl/gb5_pkg.sv
// Shared types, constants and helpers of the 5x5 RGB blur block.
// Used by the front, queue, back and top level; depends on nothing else.
package gb5_pkg;

  // Largest supported row length and derived widths.
  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int EW_W       = $clog2(MAX_WIDTH + 1);
  localparam int LEAD_W     = $clog2(2 * MAX_WIDTH + 4);
  localparam int RING_AW    = $clog2(4 * MAX_WIDTH + 16);
  localparam int RING_DEPTH = 1 << RING_AW;

  // Fixed field widths.
  localparam int CFG_WIDTH_W = 12;
  localparam int ROW_W       = 16;
  localparam int OUT_COL_W   = 11;
  localparam int CHAN_W      = 8;
  localparam int PIXEL_W     = 3 * CHAN_W;
  localparam int HSUM_W      = 12;
  localparam int VSUM_W      = 16;

  localparam int TAPS        = 5;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [TAPS-1:0][PIXEL_W-1:0] column_t;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    PF_IDLE,
    PF_COL1,
    PF_MAIN
  } pf_state_t;

  // Effective frame geometry.
  typedef struct packed {
    logic [EW_W-1:0]  width;
    logic [ROW_W-1:0] height;
  } geom_t;

  // One output pixel to be computed by the back part.
  typedef struct packed {
    logic [COL_W-1:0]   ex;
    logic [ROW_W-1:0]   ey;
    logic [RING_AW-1:0] ep;
    logic               last;
  } job_t;

  // Write port of the line stores.
  typedef struct packed {
    logic               we;
    logic [RING_AW-1:0] addr;
    pixel_t             data;
  } store_wr_t;

  // Binomial weights 1, 4, 6, 4, 1.
  function automatic logic [2:0] tap_weight(input int idx);
    logic [2:0] wt;
    case (idx)
      0, 4:    wt = 3'd1;
      1, 3:    wt = 3'd4;
      2:       wt = 3'd6;
      default: wt = 3'd0;
    endcase
    return wt;
  endfunction

endpackage

### rtl/gb5_in_if.sv
// Input stream channel of the blur block: handshake and pixel payload.
// Standalone; no package needed.
interface gb5_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, operation, red_in, green_in, blue_in, input ready);
  modport sink (input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

### rtl/gb5_out_if.sv
// Output stream channel of the blur block: handshake and result payload.
// Standalone; no package needed.
interface gb5_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [10:0] out_column;
  logic [15:0] out_row;
  logic        frame_done;

  modport source (output valid, red_out, green_out, blue_out, out_column, out_row,
                  frame_done, input ready);
  modport sink (input valid, red_out, green_out, blue_out, out_column, out_row,
                frame_done, output ready);
endinterface

### rtl/gb5_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module gb5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/gb5_front.sv
// Front part of the blur block: configuration, pixel intake, line-store
// writes and the decision which item releases which output pixel. Uses gb5_pkg.
module gb5_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  gb5_in_if.sink              pixels,
  input  logic                queue_full,
  output logic                queue_push,
  output gb5_pkg::job_t       job,
  output gb5_pkg::store_wr_t  store_wr,
  output gb5_pkg::geom_t      geom
);
  import gb5_pkg::*;

  logic [CFG_WIDTH_W-1:0] image_width;
  logic [ROW_W-1:0]       image_height;
  logic [COL_W-1:0]       in_column;
  logic [ROW_W-1:0]       in_row;
  logic [COL_W-1:0]       emit_column;
  logic [ROW_W-1:0]       emit_row;
  logic [RING_AW-1:0]     wp;
  logic [RING_AW-1:0]     ep;
  logic [LEAD_W-1:0]      lead;

  logic [EW_W-1:0]        width;
  logic [ROW_W-1:0]       height;
  logic                   accept;
  logic                   push_ok;
  logic [EW_W-1:0]        col_inc;
  logic [COL_W-1:0]       in_column_next;
  logic [ROW_W-1:0]       in_row_next;
  logic [LEAD_W-1:0]      lead_inc;
  logic [LEAD_W-1:0]      threshold;
  logic                   complete;
  logic                   emit;
  logic                   last;
  logic [EW_W-1:0]        emit_inc;
  logic [RING_AW-1:0]     wp_next;

  // Effective geometry: zero counts as one, width saturates.
  always_comb begin
    if (image_width == '0) begin
      width = EW_W'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      width = EW_W'(MAX_WIDTH);
    end else begin
      width = EW_W'(image_width);
    end
    height = (image_height == '0) ? ROW_W'(1) : image_height;
  end

  assign geom.width  = width;
  assign geom.height = height;

  assign pixels.ready = !queue_full;
  assign accept       = pixels.valid && pixels.ready;
  assign push_ok      = (op_t'(pixels.operation) == OP_PUSH) && (in_row < height);

  // Input position after this item.
  always_comb begin
    col_inc        = EW_W'(in_column) + EW_W'(1);
    in_column_next = in_column;
    in_row_next    = in_row;
    if (push_ok) begin
      if (col_inc >= width) begin
        in_column_next = '0;
        in_row_next    = in_row + ROW_W'(1);
      end else begin
        in_column_next = COL_W'(col_inc);
      end
    end
  end

  // Release test: enough pixels are in, or the frame is complete.
  assign lead_inc  = lead + LEAD_W'(push_ok);
  assign threshold = (LEAD_W'(width) << 1) + LEAD_W'(3);
  assign complete  = in_row_next >= height;
  assign emit      = complete || (lead_inc >= threshold);
  assign last      = (EW_W'(emit_column) == width - EW_W'(1)) &&
                     (emit_row == height - ROW_W'(1));
  assign emit_inc  = EW_W'(emit_column) + EW_W'(1);
  assign wp_next   = wp + RING_AW'(push_ok);

  assign queue_push = accept && emit;
  assign job.ex     = emit_column;
  assign job.ey     = emit_row;
  assign job.ep     = ep;
  assign job.last   = last;

  assign store_wr.we   = accept && push_ok;
  assign store_wr.addr = wp;
  assign store_wr.data = {pixels.red_in, pixels.green_in, pixels.blue_in};

  // Registers and positions.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_WIDTH_W'(640);
      image_height <= ROW_W'(480);
      in_column    <= '0;
      in_row       <= '0;
      emit_column  <= '0;
      emit_row     <= '0;
      wp           <= '0;
      ep           <= '0;
      lead         <= '0;
    end else if (cfg_write_en) begin
      case (reg_index_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default:          image_width  <= image_width;
      endcase
      in_column   <= '0;
      in_row      <= '0;
      emit_column <= '0;
      emit_row    <= '0;
      lead        <= '0;
      ep          <= wp;
    end else if (accept) begin
      wp <= wp_next;
      if (emit && last) begin
        // Last pixel of the frame: the next frame starts at the write pointer.
        in_column   <= '0;
        in_row      <= '0;
        emit_column <= '0;
        emit_row    <= '0;
        lead        <= '0;
        ep          <= wp_next;
      end else begin
        in_column <= in_column_next;
        in_row    <= in_row_next;
        if (emit) begin
          lead <= lead_inc - LEAD_W'(1);
          ep   <= ep + RING_AW'(1);
          if (emit_inc >= width) begin
            emit_column <= '0;
            emit_row    <= emit_row + ROW_W'(1);
          end else begin
            emit_column <= COL_W'(emit_inc);
          end
        end else begin
          lead <= lead_inc;
        end
      end
    end
  end

endmodule

### rtl/gb5_queue.sv
// Short job queue between the front and the back part.
// Uses gb5_pkg for the job type and depth.
module gb5_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gb5_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output gb5_pkg::job_t head
);
  import gb5_pkg::*;

  localparam int QA_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  job_t            entries [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QC_W-1:0] count;

  assign full       = count == QC_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QA_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QA_W'(1);
      end
      count <= count + QC_W'(push) - QC_W'(pop);
    end
  end

endmodule

### rtl/gb5_back.sv
// Back part of the blur block: reads one five-row column of the line stores
// per job, keeps the 5x5 window and computes the weighted sums. Uses gb5_pkg.
module gb5_back (
  input  logic                                        clk,
  input  logic                                        rst,
  input  gb5_pkg::geom_t                              geom,
  input  logic                                        head_valid,
  input  gb5_pkg::job_t                               head,
  output logic                                        pop,
  output logic                                        rd_en,
  output logic [gb5_pkg::TAPS-1:0][gb5_pkg::RING_AW-1:0] rd_addr,
  input  gb5_pkg::column_t                            rd_data,
  gb5_out_if.source                                   blurred
);
  import gb5_pkg::*;

  pf_state_t          state;
  pf_state_t          state_next;
  logic               en;
  logic               issue;
  logic               is_pre;
  logic               pre_j;
  logic               first;
  logic               w1;
  logic [EW_W:0]      k;
  logic [EW_W:0]      k_wrap;
  logic [ROW_W:0]     yc;
  logic [RING_AW-1:0] base;
  logic [RING_AW-1:0] wa;
  logic               col_ok;
  logic               newcol;
  logic               prew;
  logic               pre_idx;
  logic [TAPS-1:0]    row_ok;
  logic [ROW_W+1:0]   h2;

  // Read stage registers.
  logic               b_valid;
  logic               b_pre;
  logic               b_w1;
  logic               b_newcol;
  logic               b_prew;
  logic               b_idx;
  logic               b_col_ok;
  logic [TAPS-1:0]    b_row_ok;
  job_t               b_meta;
  column_t            col_data;

  // Window stage.
  column_t            win [TAPS];
  column_t            pre [2];
  logic               c_valid;
  job_t               c_meta;

  // Row sum stage.
  logic [HSUM_W-1:0]  hsum [TAPS][3];
  logic [HSUM_W-1:0]  hsum_next [TAPS][3];
  logic               h_valid;
  job_t               h_meta;
  logic [VSUM_W-1:0]  vsum [3];

  // Output register.
  logic               ov;

  assign en = !ov || blurred.ready;

  // Job sequencing: the first pixel of a frame is preceded by two column
  // prefetches that fill the start of the first row's window.
  assign first = (head.ex == '0) && (head.ey == '0);
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    is_pre     = 1'b0;
    pre_j      = 1'b0;
    pop        = 1'b0;
    if (en && head_valid) begin
      issue = 1'b1;
      case (state)
        PF_IDLE: begin
          if (first) begin
            is_pre     = 1'b1;
            state_next = PF_COL1;
          end else begin
            pop = 1'b1;
          end
        end
        PF_COL1: begin
          is_pre     = 1'b1;
          pre_j      = 1'b1;
          state_next = PF_MAIN;
        end
        PF_MAIN: begin
          pop        = 1'b1;
          state_next = PF_IDLE;
        end
        default: state_next = PF_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PF_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Which column to read: the column two to the right in the current rows,
  // near the row end a start column of the next row; own column at width one.
  assign w1     = geom.width == EW_W'(1);
  assign k      = (EW_W + 1)'(head.ex) + (EW_W + 1)'(2);
  assign k_wrap = k - (EW_W + 1)'(geom.width);
  always_comb begin
    yc      = (ROW_W + 1)'(head.ey);
    base    = head.ep + RING_AW'(2);
    col_ok  = 1'b1;
    newcol  = 1'b0;
    prew    = 1'b0;
    pre_idx = 1'b0;
    if (is_pre) begin
      yc      = '0;
      base    = head.ep + RING_AW'(pre_j);
      col_ok  = (EW_W)'(pre_j) < geom.width;
      prew    = 1'b1;
      pre_idx = pre_j;
    end else if (w1) begin
      base = head.ep;
    end else if (k < (EW_W + 1)'(geom.width)) begin
      newcol = 1'b1;
    end else begin
      yc      = (ROW_W + 1)'(head.ey) + (ROW_W + 1)'(1);
      prew    = 1'b1;
      pre_idx = k_wrap[0];
    end
  end

  // Five row addresses and the row border mask.
  assign wa    = RING_AW'(geom.width);
  assign h2    = (ROW_W + 2)'(geom.height) + (ROW_W + 2)'(2);
  assign rd_en = en;
  always_comb begin
    for (int d = 0; d < TAPS; d++) begin
      rd_addr[d] = base + wa * RING_AW'(d) - (wa << 1);
      row_ok[d]  = ((ROW_W + 2)'(yc) + (ROW_W + 2)'(d) >= (ROW_W + 2)'(2)) &&
                   ((ROW_W + 2)'(yc) + (ROW_W + 2)'(d) < h2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_pre    <= is_pre;
      b_w1     <= w1;
      b_newcol <= newcol;
      b_prew   <= prew;
      b_idx    <= pre_idx;
      b_col_ok <= col_ok;
      b_row_ok <= row_ok;
      b_meta   <= head;
    end
  end

  // Masked read column.
  always_comb begin
    for (int d = 0; d < TAPS; d++) begin
      col_data[d] = (b_row_ok[d] && b_col_ok) ? rd_data[d] : '0;
    end
  end

  // Window and prefetch columns.
  always_ff @(posedge clk) begin
    if (en && b_valid) begin
      if (b_prew) begin
        pre[b_idx] <= col_data;
      end
      if (!b_pre) begin
        if (b_w1) begin
          win[0] <= '0;
          win[1] <= '0;
          win[2] <= col_data;
          win[3] <= '0;
          win[4] <= '0;
        end else if (b_meta.ex == '0) begin
          win[0] <= '0;
          win[1] <= '0;
          win[2] <= pre[0];
          win[3] <= pre[1];
          win[4] <= b_newcol ? col_data : '0;
        end else begin
          for (int c = 0; c < TAPS - 1; c++) begin
            win[c] <= win[c+1];
          end
          win[TAPS-1] <= b_newcol ? col_data : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid && !b_pre;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_meta <= b_meta;
    end
  end

  // Horizontal weighted sums per row and channel.
  always_comb begin
    for (int d = 0; d < TAPS; d++) begin
      for (int ch = 0; ch < 3; ch++) begin
        hsum_next[d][ch] = '0;
        for (int c = 0; c < TAPS; c++) begin
          hsum_next[d][ch] = hsum_next[d][ch] + HSUM_W'(tap_weight(c)) *
                             HSUM_W'(win[c][d][PIXEL_W-1-CHAN_W*ch -: CHAN_W]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (en) begin
      h_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hsum   <= hsum_next;
      h_meta <= c_meta;
    end
  end

  // Vertical weighted sums.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      vsum[ch] = '0;
      for (int d = 0; d < TAPS; d++) begin
        vsum[ch] = vsum[ch] + VSUM_W'(tap_weight(d)) * VSUM_W'(hsum[d][ch]);
      end
    end
  end

  // Output register; divide by 256 keeps the high byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blurred.red_out    <= vsum[0][VSUM_W-1 -: CHAN_W];
      blurred.green_out  <= vsum[1][VSUM_W-1 -: CHAN_W];
      blurred.blue_out   <= vsum[2][VSUM_W-1 -: CHAN_W];
      blurred.out_column <= OUT_COL_W'(h_meta.ex);
      blurred.out_row    <= h_meta.ey;
      blurred.frame_done <= h_meta.last;
    end
  end

  assign blurred.valid = ov;

endmodule

### rtl/gaussian_blur_5x5_rgb.sv
// Top level of the 5x5 binomial RGB blur: front, job queue, back and the
// five line-store copies. Uses gb5_pkg, gb5_in_if, gb5_out_if and gb5_ram.
//
// Usage:
//   pixels carries one item per transfer: operation 0 pushes an RGB pixel in
//   raster order, operation 1 is a flush tick after the frame is in. blurred
//   carries one result per releasing item: the blurred pixel, its column and
//   row, and frame_done on the last pixel of the frame.
//   Output pixel p is released by the push of pixel p + 2*width + 2; once the
//   whole frame is in, each item releases the next pending pixel.
//   Throughput is one item per cycle while the job queue is not full. The
//   back part reads one five-row column of the line stores per output pixel;
//   the first pixel of each frame needs two extra column reads for the
//   prefetch, which the job queue absorbs. From the releasing transfer the
//   result passes the job queue, store read, window, row sums and column sums
//   into the output register, the first pixel also after the prefetch.
//   A write on the configuration port restarts the frame.
//   Reset is synchronous: width 640, height 480, all positions zero. There is
//   no clearing pass: every tap that counts was written earlier in the frame.
//   When blurred stalls, the pipeline holds, the queue fills and pixels.ready
//   drops after at most four more releasing transfers.
module gaussian_blur_5x5_rgb (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  gb5_in_if.sink      pixels,
  gb5_out_if.source   blurred
);
  import gb5_pkg::*;

  geom_t                          geom;
  job_t                           push_job;
  job_t                           head;
  logic                           queue_push;
  logic                           queue_full;
  logic                           head_valid;
  logic                           pop;
  store_wr_t                      store_wr;
  logic                           rd_en;
  logic [TAPS-1:0][RING_AW-1:0]   rd_addr;
  column_t                        rd_data;

  gb5_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixels       (pixels),
    .queue_full   (queue_full),
    .queue_push   (queue_push),
    .job          (push_job),
    .store_wr     (store_wr),
    .geom         (geom)
  );

  gb5_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (queue_push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // One line-store copy per window row, all written with the same pixel.
  for (genvar d = 0; d < TAPS; d++) begin : g_store
    gb5_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (RING_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (store_wr.we),
      .waddr (store_wr.addr),
      .wdata (store_wr.data),
      .re    (rd_en),
      .raddr (rd_addr[d]),
      .rdata (rd_data[d])
    );
  end

  gb5_back u_back (
    .clk        (clk),
    .rst        (rst),
    .geom       (geom),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .blurred    (blurred)
  );

endmodule
